### hw/rtl/fqfs_pkg.sv
// ----------------------------------------------------------------------------
// fqfs_pkg
// Shared types and constants of the queue with front sum: request and
// result codes, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package fqfs_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 12;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE   = 3'd0,
    ACT_DEQUEUE   = 3'd1,
    ACT_REAR      = 3'd2,
    ACT_FRONT_SUM = 3'd3,
    ACT_SIZE      = 3'd4,
    ACT_IS_EMPTY  = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID  = 3'd0,
    ST_DONE   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_TOOBIG = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_FINISH
  } state_e;

endpackage

### hw/rtl/fqfs_req_if.sv
// ----------------------------------------------------------------------------
// fqfs_req_if
// Request channel: valid/ready handshake with action, value and count.
// ----------------------------------------------------------------------------
interface fqfs_req_if
  import fqfs_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [DATA_W-1:0]   value;
  logic [COUNT_W-1:0]         count;

  modport source (output valid, output action, output value, output count, input ready);
  modport sink   (input valid, input action, input value, input count, output ready);
endinterface

### hw/rtl/fqfs_rsp_if.sv
// ----------------------------------------------------------------------------
// fqfs_rsp_if
// Result channel: valid/ready handshake with status and data.
// ----------------------------------------------------------------------------
interface fqfs_rsp_if
  import fqfs_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [DATA_W-1:0]   data;

  modport source (output valid, output status, output data, input ready);
  modport sink   (input valid, input status, input data, output ready);
endinterface

### hw/rtl/fifo_queue_with_front_sum_core.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_front_sum_core
// Bounded FIFO of signed 32-bit words in a ring memory, with a front-N sum.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. Enqueue, size, is-empty, unused
// codes and all error cases go straight from transfer to the finish state;
// dequeue and rear first pass a read state, as they wait for the registered
// memory read. A front sum of N words takes one memory read and one
// accumulator add per word, through the single read port of the ring memory.
// The request side is ready again once the result sits in the output
// register, so the next request can be taken while a result still waits to
// be collected. No clearing pass after reset: only occupied slots' data is used.
// ----------------------------------------------------------------------------
module fifo_queue_with_front_sum_core
  import fqfs_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fqfs_req_if.sink    req_i,
  fqfs_rsp_if.source  rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (OW > COUNT_W) ? OW : COUNT_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;

  state_e            state_q, state_d;
  logic [AW-1:0]     front_q, front_d;
  logic [OW-1:0]     occ_q, occ_d;
  logic [AW-1:0]     walk_q, walk_d;
  logic [COUNT_W-1:0] left_q, left_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  status_e           res_status_q, res_status_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic              out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;

  logic              req_fire;
  logic              is_empty;
  logic              is_full;
  logic              too_big;
  logic              out_free;
  action_e           action;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [OW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(k);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign req_i.ready  = (state_q == S_IDLE);
  assign req_fire     = req_i.valid && req_i.ready;
  assign action       = action_e'(req_i.action);
  assign is_empty     = (occ_q == '0);
  assign is_full      = (occ_q == OW'(DEPTH));
  assign too_big      = (CW'(req_i.count) > CW'(occ_q));
  assign out_free     = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.data   = out_data_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          case (action)
            ACT_DEQUEUE, ACT_REAR: begin
              state_d = is_empty ? S_FINISH : S_READ;
            end
            ACT_FRONT_SUM: begin
              if (!is_empty && !too_big && (req_i.count != '0)) begin
                state_d = S_SUM;
              end else begin
                state_d = S_FINISH;
              end
            end
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_READ: state_d = S_FINISH;
      S_SUM: begin
        if (left_q == COUNT_W'(1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    front_d      = front_q;
    occ_d        = occ_q;
    walk_d       = walk_q;
    left_d       = left_q;
    acc_d        = acc_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    rd_addr      = walk_q;
    wr_en        = 1'b0;
    wr_addr      = ring_add(front_q, occ_q);

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        rd_addr = front_q;
        if (req_fire) begin
          res_data_d = '0;
          acc_d      = '0;
          case (action)
            ACT_ENQUEUE: begin
              if (is_full) begin
                res_status_d = ST_FULL;
              end else begin
                wr_en        = 1'b1;
                occ_d        = occ_q + OW'(1);
                res_status_d = ST_DONE;
              end
            end
            ACT_DEQUEUE: begin
              if (is_empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                front_d      = ring_inc(front_q);
                occ_d        = occ_q - OW'(1);
                res_status_d = ST_VALID;
              end
            end
            ACT_REAR: begin
              rd_addr = ring_add(front_q, occ_q - OW'(1));
              res_status_d = is_empty ? ST_EMPTY : ST_VALID;
            end
            ACT_FRONT_SUM: begin
              walk_d = ring_inc(front_q);
              left_d = req_i.count;
              if (is_empty) begin
                res_status_d = ST_EMPTY;
              end else if (too_big) begin
                res_status_d = ST_TOOBIG;
              end else begin
                res_status_d = ST_VALID;
              end
            end
            ACT_SIZE: begin
              res_status_d = ST_VALID;
              res_data_d   = DATA_W'(occ_q);
            end
            ACT_IS_EMPTY: begin
              res_status_d = ST_VALID;
              res_data_d   = DATA_W'(is_empty);
            end
            default: res_status_d = ST_DONE;
          endcase
        end
      end
      S_READ: begin
        res_data_d = rd_data_q;
      end
      S_SUM: begin
        acc_d  = acc_q + rd_data_q;
        left_d = left_q - COUNT_W'(1);
        walk_d = ring_inc(walk_q);
        if (left_q == COUNT_W'(1)) begin
          res_data_d = acc_q + rd_data_q;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
        end
      end
      default: ;
    endcase
  end

  // ring memory, single write port and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= req_i.value;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q       <= walk_d;
    left_q       <= left_d;
    acc_q        <= acc_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(DEPTH))
    else $error("occupancy above depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && (req_i.action == ACT_ENQUEUE) && !is_full)
      |=> (occ_q == $past(occ_q) + OW'(1)))
    else $error("enqueue did not grow the queue");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_i.ready)
    else $error("request taken while busy");

  a_sum_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> (left_q != '0) && (CW'(left_q) <= CW'(occ_q)))
    else $error("front sum walk out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=> out_valid_q && $stable(out_data_q))
    else $error("pending result lost");
`endif

endmodule
